FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each macro expects signals named clk and rst_n in the
// scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants and shared types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Field widths
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;

  // Hue geometry
  localparam int FULL_TURN  = 360;
  localparam int SECTOR_DEG = 60;
  localparam int SEC_W      = 3;
  localparam int REM_W      = 6;

  // Scaled value 255*V
  localparam int A_W = PCT_W + CH_W;

  // Every level is floor(A * M / LVL_DEN) with M = LVL_FULL - S*k
  localparam int M_W      = 13;
  localparam int LVL_FULL = 6000;
  localparam int X_W      = A_W + M_W;
  localparam logic [63:0] LVL_DEN = 64'd600000;

  // Ceiling reciprocal of LVL_DEN; exact for every product below 2^X_W
  localparam int RECIP_SH = 48;
  localparam int RECIP_W  = 29;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) / LVL_DEN) + 64'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int PROD_W = X_W + RECIP_W;
  localparam int LVL_W  = PROD_W - RECIP_SH;

  // Register stages from the input side to the output register
  localparam int NUM_STG = 5;

  // Level lanes
  localparam int NUM_LVL = 4;
  localparam int LVL_V   = 0;
  localparam int LVL_P   = 1;
  localparam int LVL_Q   = 2;
  localparam int LVL_T   = 3;

  // Hue sectors
  typedef logic [SEC_W-1:0] sector_t;
  localparam sector_t SEC_R_Y = 3'd0;
  localparam sector_t SEC_Y_G = 3'd1;
  localparam sector_t SEC_G_C = 3'd2;
  localparam sector_t SEC_C_B = 3'd3;
  localparam sector_t SEC_B_M = 3'd4;
  localparam sector_t SEC_M_R = 3'd5;

  typedef logic [NUM_LVL-1:0][M_W-1:0]   mvec_t;
  typedef logic [NUM_LVL-1:0][LVL_W-1:0] lvec_t;

  // Load enables of the pipeline stages below the output register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

FILE: src/hsv_in_if.sv
// ----------------------------------------------------------------------------
// hsv_in_if
// Input channel: one HSV color per beat.
// ----------------------------------------------------------------------------
interface hsv_in_if import hsv2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_deg;
  logic [PCT_W-1:0] saturation_pct;
  logic [PCT_W-1:0] value_pct;

  modport source (output valid, output hue_deg, output saturation_pct,
                  output value_pct, input ready);
  modport sink   (input valid, input hue_deg, input saturation_pct,
                  input value_pct, output ready);
endinterface

FILE: src/hsv_out_if.sv
// ----------------------------------------------------------------------------
// hsv_out_if
// Result channel: one RGB color per beat.
// ----------------------------------------------------------------------------
interface hsv_out_if import hsv2rgb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

FILE: src/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stages 1 and 2: hue wrap and sector split, 255*V, and the four level
// multipliers M = 6000 - S*k, clamped at zero.
// ----------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  pipe_en_t         en,
  input  logic [HUE_W-1:0] hue,
  input  logic [PCT_W-1:0] sat,
  input  logic [PCT_W-1:0] val,
  output logic [A_W-1:0]   a2,
  output mvec_t            m2,
  output sector_t          sec2
);

  // Stage 1 registers
  sector_t          sec1_r, sec1_nxt;
  logic [REM_W-1:0] rem1_r, rem1_nxt;
  logic [PCT_W-1:0] s1_r;
  logic [A_W-1:0]   a1_r, a1_nxt;

  // Stage 2 registers
  sector_t        sec2_r;
  logic [A_W-1:0] a2_r;
  mvec_t          m2_r, m2_nxt;

  logic [HUE_W-1:0] h_wrap;
  logic [HUE_W-1:0] h_base;
  logic [HUE_W-1:0] h_rem;

  logic [NUM_LVL-1:0][REM_W-1:0] k;
  logic [M_W-1:0]                sk;
  logic [M_W:0]                  m_s;

  // Hue wrap, sector and remainder
  always_comb begin
    h_wrap = (hue >= HUE_W'(FULL_TURN)) ? hue - HUE_W'(FULL_TURN) : hue;
    priority if (h_wrap >= HUE_W'(5 * SECTOR_DEG)) begin
      sec1_nxt = SEC_M_R;
      h_base   = HUE_W'(5 * SECTOR_DEG);
    end else if (h_wrap >= HUE_W'(4 * SECTOR_DEG)) begin
      sec1_nxt = SEC_B_M;
      h_base   = HUE_W'(4 * SECTOR_DEG);
    end else if (h_wrap >= HUE_W'(3 * SECTOR_DEG)) begin
      sec1_nxt = SEC_C_B;
      h_base   = HUE_W'(3 * SECTOR_DEG);
    end else if (h_wrap >= HUE_W'(2 * SECTOR_DEG)) begin
      sec1_nxt = SEC_G_C;
      h_base   = HUE_W'(2 * SECTOR_DEG);
    end else if (h_wrap >= HUE_W'(SECTOR_DEG)) begin
      sec1_nxt = SEC_Y_G;
      h_base   = HUE_W'(SECTOR_DEG);
    end else begin
      sec1_nxt = SEC_R_Y;
      h_base   = '0;
    end
    h_rem    = h_wrap - h_base;
    rem1_nxt = h_rem[REM_W-1:0];
    // 255*V as a shift and subtract
    a1_nxt   = A_W'({val, {CH_W{1'b0}}}) - A_W'(val);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sec1_r <= sec1_nxt;
      rem1_r <= rem1_nxt;
      s1_r   <= sat;
      a1_r   <= a1_nxt;
    end
  end

  // Per-lane k: v uses 0, p uses 60, q uses rem, t uses 60 - rem
  always_comb begin
    k[LVL_V] = '0;
    k[LVL_P] = REM_W'(SECTOR_DEG);
    k[LVL_Q] = rem1_r;
    k[LVL_T] = REM_W'(SECTOR_DEG) - rem1_r;
    sk       = '0;
    m_s      = '0;
    for (int i = 0; i < NUM_LVL; i++) begin
      sk  = M_W'(s1_r) * M_W'(k[i]);
      m_s = (M_W + 1)'(LVL_FULL) - {1'b0, sk};
      // negative multiplier floors to a zero level
      m2_nxt[i] = m_s[M_W] ? '0 : m_s[M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sec2_r <= sec1_r;
      a2_r   <= a1_r;
      m2_r   <= m2_nxt;
    end
  end

  assign a2   = a2_r;
  assign m2   = m2_r;
  assign sec2 = sec2_r;

endmodule

FILE: src/hsv2rgb_lane.sv
// ----------------------------------------------------------------------------
// hsv2rgb_lane
// Stages 3 and 4 of one level: product A*M, then division by 600000
// through a ceiling reciprocal multiply.
// ----------------------------------------------------------------------------
module hsv2rgb_lane import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  pipe_en_t         en,
  input  logic [A_W-1:0]   a,
  input  logic [M_W-1:0]   m,
  output logic [LVL_W-1:0] lvl
);

  logic [X_W-1:0]    x3_r, x3_nxt;
  logic [LVL_W-1:0]  lvl4_r;
  logic [PROD_W-1:0] prod;

  // Stage 3: level numerator
  assign x3_nxt = X_W'(a) * X_W'(m);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      x3_r <= x3_nxt;
    end
  end

  // Stage 4: floor(x / 600000) = (x * RECIP) >> RECIP_SH
  assign prod = PROD_W'(x3_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      lvl4_r <= prod[PROD_W-1:RECIP_SH];
    end
  end

  assign lvl = lvl4_r;

endmodule

FILE: src/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to RGB color converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one beat per color: hue_deg (0..359, 360..511 wrap),
//          saturation_pct and value_pct (0..100; levels beyond 0..255 clamp).
//   out_ch gives one beat per input beat with 8-bit red, green, blue,
//          in input order.
//   Pipeline stages: hue split, level multiplier, product, reciprocal
//   multiply, clamp and sector mux into the output register.
//   Throughput: one beat per clock while the receiver does not stall.
//   Reset (rst_n low, synchronous) clears every stage's valid bit; the
//   block comes out empty with in_ch.ready high.
//   When the receiver stalls, the output beat holds and stages fill up
//   behind it; in_ch.ready drops only when every stage holds a beat.
//   Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit import hsv2rgb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  hsv_in_if.sink   in_ch,
  hsv_out_if.source out_ch
);

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic [NUM_STG-1:0] rdy;
  pipe_en_t           pen;

  logic [A_W-1:0] a2;
  mvec_t          m2;
  sector_t        sec2;
  sector_t        sec3_r, sec4_r;
  lvec_t          lvl;
  logic [NUM_LVL-1:0][CH_W-1:0] lc;

  logic [CH_W-1:0] red_r, red_nxt;
  logic [CH_W-1:0] grn_r, grn_nxt;
  logic [CH_W-1:0] blu_r, blu_nxt;

  // Per-stage ready: a stage takes a beat when empty or when it moves on
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ch.ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[0];
  assign pen.s1      = rdy[0];
  assign pen.s2      = rdy[1];
  assign pen.s3      = rdy[2];
  assign pen.s4      = rdy[3];

  // Valid bits travel with the data
  always_comb begin
    vld_nxt[0] = rdy[0] ? in_ch.valid : vld_r[0];
    for (int i = 1; i < NUM_STG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stages 1-2
  hsv2rgb_front u_front (
    .clk  (clk),
    .en   (pen),
    .hue  (in_ch.hue_deg),
    .sat  (in_ch.saturation_pct),
    .val  (in_ch.value_pct),
    .a2   (a2),
    .m2   (m2),
    .sec2 (sec2)
  );

  // Stages 3-4, one lane per level
  for (genvar g = 0; g < NUM_LVL; g++) begin : g_lane
    hsv2rgb_lane u_lane (
      .clk (clk),
      .en  (pen),
      .a   (a2),
      .m   (m2[g]),
      .lvl (lvl[g])
    );
  end

  // Sector rides alongside the lanes
  always_ff @(posedge clk) begin
    if (pen.s3) begin
      sec3_r <= sec2;
    end
    if (pen.s4) begin
      sec4_r <= sec3_r;
    end
  end

  // Stage 5: clamp to 255 and route levels by sector
  always_comb begin
    for (int i = 0; i < NUM_LVL; i++) begin
      lc[i] = lvl[i][LVL_W-1:CH_W] != '0 ? {CH_W{1'b1}} : lvl[i][CH_W-1:0];
    end
    unique case (sec4_r)
      SEC_R_Y: begin
        red_nxt = lc[LVL_V]; grn_nxt = lc[LVL_T]; blu_nxt = lc[LVL_P];
      end
      SEC_Y_G: begin
        red_nxt = lc[LVL_Q]; grn_nxt = lc[LVL_V]; blu_nxt = lc[LVL_P];
      end
      SEC_G_C: begin
        red_nxt = lc[LVL_P]; grn_nxt = lc[LVL_V]; blu_nxt = lc[LVL_T];
      end
      SEC_C_B: begin
        red_nxt = lc[LVL_P]; grn_nxt = lc[LVL_Q]; blu_nxt = lc[LVL_V];
      end
      SEC_B_M: begin
        red_nxt = lc[LVL_T]; grn_nxt = lc[LVL_P]; blu_nxt = lc[LVL_V];
      end
      default: begin
        red_nxt = lc[LVL_V]; grn_nxt = lc[LVL_P]; blu_nxt = lc[LVL_Q];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STG-1]) begin
      red_r <= red_nxt;
      grn_r <= grn_nxt;
      blu_r <= blu_nxt;
    end
  end

  assign out_ch.valid = vld_r[NUM_STG-1];
  assign out_ch.red   = red_r;
  assign out_ch.green = grn_r;
  assign out_ch.blue  = blu_r;

endmodule

FILE: src/hsv2rgb_chk.sv
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks of the converter: output hold under stall, ready
// propagation, drain and fixed latency through the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_chk import hsv2rgb_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] red,
  input logic [CH_W-1:0] green,
  input logic [CH_W-1:0] blue
);

  logic               acc;
  logic               quiet;
  logic               stall;
  logic [3*CH_W-1:0]  rgb;
  logic [NUM_STG-1:0] quiet_h_r;
  logic [NUM_STG-1:0] acc_h_r;
  logic [NUM_STG-1:0] ordy_h_r;

  assign acc   = in_valid && in_ready;
  assign quiet = !acc && out_ready;
  assign stall = out_valid && !out_ready;
  assign rgb   = {red, green, blue};

  // Short histories; cleared by reset so no window spans it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_h_r <= '0;
      acc_h_r   <= '0;
      ordy_h_r  <= '0;
    end else begin
      quiet_h_r <= {quiet_h_r[NUM_STG-2:0], quiet};
      acc_h_r   <= {acc_h_r[NUM_STG-2:0], acc};
      ordy_h_r  <= {ordy_h_r[NUM_STG-2:0], out_ready};
    end
  end

  // Stalled output beat holds
  `ASSERT_NXT(a_hold, stall, out_valid && $stable(rgb), "out beat changed under stall")

  // A ready receiver frees the whole pipeline
  `ASSERT_IMP(a_rdy, out_ready, in_ready, "in not ready while out ready")

  // A full history of quiet cycles (no input, receiver ready) leaves no output
  `ASSERT_IMP(a_drain, &quiet_h_r, !out_valid, "out beat without input")

  // Without stall an accepted beat shows as out_valid when its acceptance reaches the end of the history
  `ASSERT_IMP(a_lat, acc_h_r[NUM_STG-1] && (&ordy_h_r[NUM_STG-2:0]), out_valid, "beat late")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red       (out_ch.red),
  .green     (out_ch.green),
  .blue      (out_ch.blue)
);
